// File: hdl/utf8tce_pkg.sv
// ----------------------------------------------------------------------------
// utf8tce_pkg
// Types, constants and helpers for the UTF-8 token count estimator.
// ----------------------------------------------------------------------------
package utf8tce_pkg;

   localparam int FIELD_W = 21;
   localparam int RATIO_W = 16;
   localparam int PROD_W  = FIELD_W + RATIO_W;
   localparam int X_W     = 22;
   localparam int RECIP_W = 24;
   localparam int RECIP_SH = 25;
   localparam int CSR_IDX_W = 2;

   localparam longint MAX_TEXT_BYTES = 64'd1048576;
   localparam longint FIELD_MAX = (64'd1 << FIELD_W) - 64'd1;
   localparam logic [FIELD_W-1:0] COUNT_CAP =
      FIELD_W'((MAX_TEXT_BYTES < FIELD_MAX) ? MAX_TEXT_BYTES : FIELD_MAX);

   // floor(x*m >> 25) equals floor(x/d) for x below 2**22
   localparam logic [RECIP_W-1:0] RECIP3 = 24'd11184811;
   localparam logic [RECIP_W-1:0] RECIP7 = 24'd4793491;

   localparam logic [RATIO_W-1:0] CJK_RATIO_RESET   = 16'd13107;
   localparam logic [RATIO_W-1:0] ALPHA_RATIO_RESET = 16'd26214;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCURATE_MODE = 2'd0,
      CSR_MODEL_SELECT  = 2'd1,
      CSR_CJK_RATIO     = 2'd2,
      CSR_ALPHA_RATIO   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODEL_GENERIC  = 2'd0,
      MODEL_MIXED    = 2'd1,
      MODEL_SEVENTHS = 2'd2,
      MODEL_QUARTER  = 2'd3
   } rule_sel_type;

   typedef enum logic [1:0] {
      OP_PASS = 2'd0,
      OP_DIV3 = 2'd1,
      OP_DIV7 = 2'd2
   } div_op_type;

   typedef logic [FIELD_W-1:0] count_type;

   localparam logic [FIELD_W-1:0] CJK_LO [16] = '{
      21'h04E00, 21'h03400, 21'h20000, 21'h2A700, 21'h2B740, 21'h2B820,
      21'h2CEB0, 21'h30000, 21'h31350, 21'h0F900, 21'h2F800, 21'h03000,
      21'h03040, 21'h030A0, 21'h0AC00, 21'h0FF00
   };
   localparam logic [FIELD_W-1:0] CJK_HI [16] = '{
      21'h09FFF, 21'h04DBF, 21'h2A6DF, 21'h2B73F, 21'h2B81F, 21'h2CEAF,
      21'h2EBEF, 21'h3134F, 21'h323AF, 21'h0FAFF, 21'h2FA1F, 21'h0303F,
      21'h0309F, 21'h030FF, 21'h0D7AF, 21'h0FFEF
   };

   function automatic logic in_cjk(input logic [FIELD_W-1:0] cp);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 16; k++) begin
         if (cp >= CJK_LO[k] && cp <= CJK_HI[k]) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [1:0] seq_len(input logic [7:0] lead);
      logic [1:0] n;
      if (lead >= 8'hC2 && lead <= 8'hDF) n = 2'd1;
      else if (lead >= 8'hE0 && lead <= 8'hEF) n = 2'd2;
      else if (lead >= 8'hF0 && lead <= 8'hF4) n = 2'd3;
      else n = 2'd0;
      return n;
   endfunction

   function automatic count_type sat_inc(input count_type v);
      return (v < COUNT_CAP) ? v + 1'b1 : COUNT_CAP;
   endfunction

endpackage

// File: hdl/utf8tce_if.sv
// ----------------------------------------------------------------------------
// utf8tce_if
// Valid/ready channels for text bytes and for count results.
// ----------------------------------------------------------------------------
interface utf8tce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface utf8tce_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] token_estimate;
   logic [20:0] char_count;
   logic [20:0] cjk_count;
   logic [20:0] alpha_count;

   modport source (output valid, output token_estimate, output char_count,
                   output cjk_count, output alpha_count, input ready);
   modport sink   (input valid, input token_estimate, input char_count,
                   input cjk_count, input alpha_count, output ready);
endinterface

// File: hdl/utf8_token_count_estimator_core.sv
// ----------------------------------------------------------------------------
// utf8_token_count_estimator_core
// Strict UTF-8 decoder with character class counters and token estimate.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle, but a byte marked last waits in the input
// register while the estimate pipeline cannot take it; the decoder state and
// the counters form a register loop that sets this rate. Each byte goes
// through an input register, then the decoder. On the byte marked last the
// counts enter the estimate pipeline (count capture, ratio products, rule
// select, reciprocal multiply, output register). Bytes of the next text are
// taken while a result waits on the output. Configuration writes are expected
// only while the block is idle.
module utf8_token_count_estimator_core (
   input  logic                              clock,
   input  logic                              reset,
   utf8tce_req_if.sink                       req_ch,
   utf8tce_rsp_if.source                     rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [utf8tce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [utf8tce_pkg::RATIO_W-1:0]   csr_wdata
);
   import utf8tce_pkg::*;

   // configuration
   logic               acc_mode_ff;
   logic [1:0]         model_ff;
   logic [RATIO_W-1:0] cjk_ratio_ff;
   logic [RATIO_W-1:0] alpha_ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_mode_ff    <= 1'b0;
         model_ff       <= MODEL_GENERIC;
         cjk_ratio_ff   <= CJK_RATIO_RESET;
         alpha_ratio_ff <= ALPHA_RATIO_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ACCURATE_MODE: acc_mode_ff    <= csr_wdata[0];
            CSR_MODEL_SELECT:  model_ff       <= csr_wdata[1:0];
            CSR_CJK_RATIO:     cjk_ratio_ff   <= csr_wdata;
            CSR_ALPHA_RATIO:   alpha_ratio_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage flow control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic adv_o, adv5, adv4, adv3, adv2, s1_consume;

   logic [7:0] b1_ff;
   logic       last1_ff;

   assign adv_o      = !vo_ff || rsp_ch.ready;
   assign adv5       = !v5_ff || adv_o;
   assign adv4       = !v4_ff || adv5;
   assign adv3       = !v3_ff || adv4;
   assign adv2       = !v2_ff || adv3;
   assign s1_consume = v1_ff && (!last1_ff || adv2);
   assign req_ch.ready = !v1_ff || s1_consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (req_ch.ready) begin
         v1_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         b1_ff    <= req_ch.byte_value;
         last1_ff <= req_ch.last_byte;
      end
   end

   // decoder
   logic [1:0]   pend_ff, pend_in;
   logic [7:0]   lead_ff, lead_in;
   logic [20:0]  part_ff, part_in;
   count_type    tot_ff, tot_in, cjk_ff, cjk_in, alp_ff, alp_in;

   always_comb begin
      logic        ok, taken, do_count;
      logic [1:0]  n;
      logic [20:0] shifted, cp;
      ok       = (b1_ff[7:6] == 2'b10);
      taken    = 1'b0;
      do_count = 1'b0;
      n        = seq_len(b1_ff);
      shifted  = {part_ff[14:0], b1_ff[5:0]};
      cp       = {13'd0, b1_ff};
      pend_in  = pend_ff;
      lead_in  = lead_ff;
      part_in  = part_ff;
      tot_in   = tot_ff;
      cjk_in   = cjk_ff;
      alp_in   = alp_ff;
      if (pend_ff != 2'd0) begin
         if (pend_ff == seq_len(lead_ff)) begin
            if (lead_ff == 8'hE0 && b1_ff < 8'hA0) ok = 1'b0;
            if (lead_ff == 8'hED && b1_ff > 8'h9F) ok = 1'b0;
            if (lead_ff == 8'hF0 && b1_ff < 8'h90) ok = 1'b0;
            if (lead_ff == 8'hF4 && b1_ff > 8'h8F) ok = 1'b0;
         end
         if (ok) begin
            taken   = 1'b1;
            part_in = shifted;
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               do_count = 1'b1;
               cp       = shifted;
            end
         end else begin
            pend_in = 2'd0;
         end
      end
      if (!taken) begin
         if (!b1_ff[7]) begin
            do_count = 1'b1;
         end else if (n != 2'd0) begin
            pend_in = n;
            lead_in = b1_ff;
            case (n)
               2'd1:    part_in = {16'd0, b1_ff[4:0]};
               2'd2:    part_in = {17'd0, b1_ff[3:0]};
               default: part_in = {18'd0, b1_ff[2:0]};
            endcase
         end
      end
      if (do_count) begin
         tot_in = sat_inc(tot_ff);
         if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A)) begin
            alp_in = sat_inc(alp_ff);
         end else if (in_cjk(cp)) begin
            cjk_in = sat_inc(cjk_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_consume && last1_ff)) begin
         pend_ff <= 2'd0;
         lead_ff <= 8'd0;
         part_ff <= 21'd0;
         tot_ff  <= '0;
         cjk_ff  <= '0;
         alp_ff  <= '0;
      end else if (s1_consume) begin
         pend_ff <= pend_in;
         lead_ff <= lead_in;
         part_ff <= part_in;
         tot_ff  <= tot_in;
         cjk_ff  <= cjk_in;
         alp_ff  <= alp_in;
      end
   end

   // estimate pipeline
   count_type t2_ff, c2_ff, a2_ff;
   count_type t3_ff, c3_ff, a3_ff;
   count_type t4_ff, c4_ff, a4_ff;
   count_type t5_ff, c5_ff, a5_ff;
   logic [PROD_W-1:0]  pc3_ff, pa3_ff;
   logic [X_W-1:0]     x4_ff, x4_in, x5_ff;
   div_op_type         op4_ff, op4_in, op5_ff;
   logic [X_W+RECIP_W-1:0] prod5_ff;
   logic [FIELD_W-1:0] est_in, esto_ff;
   count_type to_ff, co_ff, ao_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (adv2)  v2_ff <= s1_consume && last1_ff;
         if (adv3)  v3_ff <= v2_ff;
         if (adv4)  v4_ff <= v3_ff;
         if (adv5)  v5_ff <= v4_ff;
         if (adv_o) vo_ff <= v5_ff;
      end
   end

   always_comb begin
      logic        cjk_high, alpha_high;
      logic [20:0] rest;
      logic [23:0] n_mixed;
      logic [21:0] sum_ct;
      cjk_high   = {c3_ff, 16'd0} > pc3_ff;
      alpha_high = {a3_ff, 16'd0} > pa3_ff;
      rest       = (t3_ff >= c3_ff) ? t3_ff - c3_ff : 21'd0;
      n_mixed    = {c3_ff, 3'd0} + ({3'd0, rest} << 1) + {3'd0, rest};
      sum_ct     = {1'b0, c3_ff} + {1'b0, t3_ff};
      if (acc_mode_ff) begin
         case (rule_sel_type'(model_ff))
            MODEL_MIXED: begin
               x4_in = n_mixed[23:2]; op4_in = OP_DIV3;
            end
            MODEL_SEVENTHS: begin
               x4_in = {t3_ff, 1'b0}; op4_in = OP_DIV7;
            end
            MODEL_QUARTER: begin
               x4_in = {2'd0, sum_ct[21:2]}; op4_in = OP_PASS;
            end
            default: begin
               if (cjk_high) begin
                  x4_in = n_mixed[23:2]; op4_in = OP_DIV3;
               end else if (alpha_high) begin
                  x4_in = {3'd0, t3_ff[20:2]}; op4_in = OP_PASS;
               end else begin
                  x4_in = {1'b0, t3_ff}; op4_in = OP_DIV3;
               end
            end
         endcase
      end else if (cjk_high) begin
         x4_in = {t3_ff, 1'b0}; op4_in = OP_DIV3;
      end else if (alpha_high) begin
         x4_in = {3'd0, t3_ff[20:2]}; op4_in = OP_PASS;
      end else begin
         x4_in = {1'b0, t3_ff}; op4_in = OP_DIV3;
      end
   end

   always_comb begin
      case (op5_ff)
         OP_PASS: est_in = x5_ff[FIELD_W-1:0];
         default: est_in = prod5_ff[RECIP_SH+FIELD_W-1:RECIP_SH];
      endcase
      if (est_in == '0 && t5_ff != '0) est_in = FIELD_W'(1);
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_consume && last1_ff) begin
         t2_ff <= tot_in;
         c2_ff <= cjk_in;
         a2_ff <= alp_in;
      end
      if (adv3) begin
         t3_ff  <= t2_ff;
         c3_ff  <= c2_ff;
         a3_ff  <= a2_ff;
         pc3_ff <= PROD_W'(t2_ff) * PROD_W'(cjk_ratio_ff);
         pa3_ff <= PROD_W'(t2_ff) * PROD_W'(alpha_ratio_ff);
      end
      if (adv4) begin
         t4_ff  <= t3_ff;
         c4_ff  <= c3_ff;
         a4_ff  <= a3_ff;
         x4_ff  <= x4_in;
         op4_ff <= op4_in;
      end
      if (adv5) begin
         t5_ff    <= t4_ff;
         c5_ff    <= c4_ff;
         a5_ff    <= a4_ff;
         x5_ff    <= x4_ff;
         op5_ff   <= op4_ff;
         prod5_ff <= (X_W+RECIP_W)'(x4_ff) *
                     (X_W+RECIP_W)'((op4_ff == OP_DIV7) ? RECIP7 : RECIP3);
      end
      if (adv_o) begin
         esto_ff <= est_in;
         to_ff   <= t5_ff;
         co_ff   <= c5_ff;
         ao_ff   <= a5_ff;
      end
   end

   assign rsp_ch.valid          = vo_ff;
   assign rsp_ch.token_estimate = esto_ff;
   assign rsp_ch.char_count     = to_ff;
   assign rsp_ch.cjk_count      = co_ff;
   assign rsp_ch.alpha_count    = ao_ff;

   a_est_nonzero: assert property (@(posedge clock) disable iff (reset)
      (vo_ff && to_ff != '0) |-> (esto_ff != '0))
      else $error("estimate is zero for a nonempty text");

   a_class_bound: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> ({1'b0, co_ff} + {1'b0, ao_ff} <= {1'b0, to_ff}))
      else $error("class counts exceed character count");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_consume && last1_ff) |=> (pend_ff == 2'd0 && tot_ff == '0))
      else $error("decoder state not cleared after last item");

   a_last_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (s1_consume && last1_ff) |=> v2_ff)
      else $error("last item lost before estimate pipeline");

endmodule
